/* src/priority_ready_queue_defines.svh */
// ----------------------------------------------------------------------------
// Priority ready queue assertion macros
// Shared property forms for the checker of the ready queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/prq_pkg.sv */
// ----------------------------------------------------------------------------
// Priority ready queue package
// Command and result types, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int ID_WIDTH       = 8;
    localparam int PRIO_FIELD_W   = 16;
    localparam int OCC_WIDTH      = 5;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_SORTED = 2'd1,
        FUNC_HEAD   = 2'd2,
        FUNC_POP    = 2'd3
    } prq_func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } prq_status_t;

    typedef struct packed {
        prq_func_t                 func;
        logic [ID_WIDTH-1:0]       entry_id;
        logic [PRIO_FIELD_W-1:0]   priority_req;
    } prq_req_t;

    typedef struct packed {
        logic                      out_valid;
        logic [ID_WIDTH-1:0]       out_entry_id;
        logic [PRIO_FIELD_W-1:0]   out_priority;
        prq_status_t               status;
        logic [OCC_WIDTH-1:0]      occupancy;
    } prq_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_POP,
        ST_SCAN,
        ST_PLACE,
        ST_RESP
    } prq_state_t;

endpackage

/* src/prq_ram.sv */
// ----------------------------------------------------------------------------
// Priority ready queue entry memory
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// Priority ready queue
// Bounded ready queue of process entries held in a circular entry memory.
// ----------------------------------------------------------------------------
// A command transfer takes place at a rising edge where start is high and
// busy is low. The command selects append at the tail, stable insert by
// ascending priority, insert at the head, or removal of the head.
// Every command yields exactly one result transfer, shown on rsp for one
// cycle while done is high; busy falls in the cycle after done.
// Entries live in one memory used as a ring with a head pointer and a count.
// Tail and head inserts, dropped inserts and removals from an empty queue
// pass from the dispatch state straight to the result state.
// A removal adds a pop state because it waits on the memory read of the head.
// A sorted insert reads one entry per cycle from the head and moves each
// entry with a lower or equal key one slot toward the head, then writes the
// new entry in a place state; it reads from 1 entry up to the count.
// Reset empties the queue at once; memory contents need no clearing.
// Results cannot be held off by the receiver, so the queue never stalls.
module priority_ready_queue #(
    parameter int DEPTH          = 16,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  prq_pkg::prq_req_t req,
    output logic             done,
    output prq_pkg::prq_rsp_t rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int KW   = PRIORITY_WIDTH;
    localparam int IW   = prq_pkg::ID_WIDTH;
    localparam int EW   = IW + KW;
    localparam int OccW = prq_pkg::OCC_WIDTH;
    localparam int PrW  = prq_pkg::PRIO_FIELD_W;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                              input logic [CW-1:0] n);
        logic [SW-1:0] sum;
        sum = SW'(p) + SW'(n);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    prq_pkg::prq_state_t state_reg, state_next;
    prq_pkg::prq_req_t   req_reg, req_next;
    prq_pkg::prq_rsp_t   rsp_reg, rsp_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [AW-1:0]       place_reg, place_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    logic [KW-1:0]       new_key;
    logic [EW-1:0]       new_entry;
    logic [KW-1:0]       rd_key;
    logic [IW-1:0]       rd_id;
    logic                full;
    logic                empty;

    assign new_key   = KW'(req_reg.priority_req);
    assign new_entry = {req_reg.entry_id, new_key};
    assign rd_key    = ram_rdata[KW-1:0];
    assign rd_id     = ram_rdata[EW-1:KW];
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    prq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        ptr_reg   <= ptr_next;
        scan_reg  <= scan_next;
        place_reg <= place_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        head_next  = head_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        scan_next  = scan_reg;
        place_next = place_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = new_entry;
        ram_raddr  = ptr_reg;

        case (state_reg)
            prq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = prq_pkg::ST_DISPATCH;
                end
            end

            prq_pkg::ST_DISPATCH:
            begin
                rsp_next           = '0;
                rsp_next.occupancy = OccW'(count_reg);
                state_next         = prq_pkg::ST_RESP;
                if (req_reg.func == prq_pkg::FUNC_POP)
                begin
                    if (empty)
                    begin
                        rsp_next.status = prq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        ram_raddr  = head_reg;
                        state_next = prq_pkg::ST_POP;
                    end
                end
                else if (full)
                begin
                    rsp_next.status = prq_pkg::STATUS_FULL;
                end
                else
                begin
                    case (req_reg.func)
                        prq_pkg::FUNC_APPEND:
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = ptr_add(head_reg, count_reg);
                            count_next         = count_reg + 1'b1;
                            rsp_next.occupancy = OccW'(count_reg + 1'b1);
                        end
                        prq_pkg::FUNC_HEAD:
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = ptr_dec(head_reg);
                            head_next          = ptr_dec(head_reg);
                            count_next         = count_reg + 1'b1;
                            rsp_next.occupancy = OccW'(count_reg + 1'b1);
                        end
                        prq_pkg::FUNC_SORTED:
                        begin
                            if (empty)
                            begin
                                ram_we             = 1'b1;
                                ram_waddr          = head_reg;
                                count_next         = count_reg + 1'b1;
                                rsp_next.occupancy = OccW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                ram_raddr  = head_reg;
                                ptr_next   = head_reg;
                                scan_next  = '0;
                                state_next = prq_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = prq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            prq_pkg::ST_POP:
            begin
                rsp_next.out_valid    = 1'b1;
                rsp_next.out_entry_id = rd_id;
                rsp_next.out_priority = PrW'(rd_key);
                rsp_next.status       = prq_pkg::STATUS_OK;
                rsp_next.occupancy    = OccW'(count_reg - 1'b1);
                head_next             = ptr_inc(head_reg);
                count_next            = count_reg - 1'b1;
                state_next            = prq_pkg::ST_RESP;
            end

            prq_pkg::ST_SCAN:
            begin
                if (new_key < rd_key)
                begin
                    place_next = ptr_dec(ptr_reg);
                    state_next = prq_pkg::ST_PLACE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_dec(ptr_reg);
                    ram_wdata = ram_rdata;
                    if ((scan_reg + 1'b1) == count_reg)
                    begin
                        place_next = ptr_reg;
                        state_next = prq_pkg::ST_PLACE;
                    end
                    else
                    begin
                        ptr_next  = ptr_inc(ptr_reg);
                        ram_raddr = ptr_inc(ptr_reg);
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end

            prq_pkg::ST_PLACE:
            begin
                ram_we             = 1'b1;
                ram_waddr          = place_reg;
                head_next          = ptr_dec(head_reg);
                count_next         = count_reg + 1'b1;
                rsp_next.status    = prq_pkg::STATUS_OK;
                rsp_next.occupancy = OccW'(count_reg + 1'b1);
                state_next         = prq_pkg::ST_RESP;
            end

            prq_pkg::ST_RESP:
            begin
                state_next = prq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = prq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != prq_pkg::ST_IDLE);
    assign done = (state_reg == prq_pkg::ST_RESP);
    assign rsp  = rsp_reg;

endmodule

/* src/prq_checker.sv */
// ----------------------------------------------------------------------------
// Priority ready queue checker
// Port-level properties of the ready queue, attached to it by a bind.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_defines.svh"

module prq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input prq_pkg::prq_rsp_t rsp
);

    logic cmd_accept;
    logic rsp_ok;
    logic rsp_empty;
    logic rsp_blank;

    assign cmd_accept = start && !busy;
    assign rsp_ok     = (rsp.status == prq_pkg::STATUS_OK);
    assign rsp_empty  = (rsp.status == prq_pkg::STATUS_EMPTY);
    assign rsp_blank  = (rsp.occupancy == '0) && !rsp.out_valid;

    `PRQ_ASSERT_NXT(a_cmd_takes_busy, cmd_accept, busy, "command transfer did not raise busy")
    `PRQ_ASSERT_IMP(a_done_while_busy, done, busy, "result shown while not busy")
    `PRQ_ASSERT_NXT(a_done_single, done, !done, "result strobe held longer than one cycle")
    `PRQ_ASSERT_IMP(a_valid_is_ok, done && rsp.out_valid, rsp_ok, "entry returned with bad status")
    `PRQ_ASSERT_IMP(a_empty_result, done && rsp_empty, rsp_blank, "empty status with entries or data")

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
